### rtl/core/pbss_pkg.sv
// Shared constants and controller/datapath interface types for the packet
// buffer start scheduler. No dependencies.
package pbss_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int OCC_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int TIME_W       = 32;
  localparam int DUR_W        = 16;
  localparam int SIZE_W       = 7;
  localparam int LIM_W        = (OCC_W > SIZE_W) ? OCC_W : SIZE_W;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  // register index carried in paddr[PADDR_W-1:2]
  localparam logic REG_BUFFER_SIZE = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } pbss_state_t;

  typedef struct packed {
    logic load;    // capture the incoming word
    logic pop;     // retire the head entry
    logic finish;  // decide, emit the result, append the finish time
  } pbss_cmd_t;

  typedef struct packed {
    logic head_expired;  // buffer not empty and head finish <= arrival
  } pbss_status_t;

endpackage

### rtl/core/pbss_ctrl.sv
// Controller state machine for the packet buffer start scheduler.
// Depends on pbss_pkg.
module pbss_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  pbss_pkg::pbss_status_t status,
  output pbss_pkg::pbss_cmd_t    cmd,
  output logic                  busy
);

  pbss_pkg::pbss_state_t state_r;
  pbss_pkg::pbss_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pbss_pkg::ST_IDLE: begin
        if (start) state_nxt = pbss_pkg::ST_SCAN;
      end
      pbss_pkg::ST_SCAN: begin
        if (!status.head_expired) state_nxt = pbss_pkg::ST_IDLE;
      end
      default: state_nxt = pbss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    case (state_r)
      pbss_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      pbss_pkg::ST_SCAN: begin
        busy       = 1'b1;
        cmd.pop    = status.head_expired;
        cmd.finish = !status.head_expired;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

### rtl/core/pbss_dpath.sv
// Datapath of the packet buffer start scheduler: finish-time ring memory,
// head/tail/occupancy pointers, start-time decision and result registers.
// Depends on pbss_pkg.
module pbss_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pbss_pkg::pbss_cmd_t               cmd,
  output pbss_pkg::pbss_status_t            status,
  input  logic [pbss_pkg::SIZE_W-1:0]       buffer_size,
  input  logic [pbss_pkg::TIME_W-1:0]       in_arrival_time,
  input  logic [pbss_pkg::DUR_W-1:0]        in_duration,
  output logic                              out_valid,
  output logic [pbss_pkg::TIME_W-1:0]       out_start_time,
  output logic                              out_dropped
);

  logic [pbss_pkg::TIME_W-1:0] ring_mem [pbss_pkg::BUFFER_DEPTH];

  logic [pbss_pkg::TIME_W-1:0] arrival_r;
  logic [pbss_pkg::DUR_W-1:0]  duration_r;
  logic [pbss_pkg::TIME_W-1:0] rd_data_r;
  logic [pbss_pkg::TIME_W-1:0] last_finish_r;
  logic [pbss_pkg::IDX_W-1:0]  head_r, head_nxt;
  logic [pbss_pkg::IDX_W-1:0]  tail_r, tail_nxt;
  logic [pbss_pkg::OCC_W-1:0]  occ_r, occ_nxt;
  logic                        out_valid_r;
  logic [pbss_pkg::TIME_W-1:0] out_start_r;
  logic                        out_dropped_r;

  logic [pbss_pkg::IDX_W-1:0]  head_inc, tail_inc, rd_addr;
  logic                        occ_zero;
  logic [pbss_pkg::LIM_W-1:0]  size_ext, limit;
  logic                        full;
  logic [pbss_pkg::TIME_W-1:0] start_sel;
  logic [pbss_pkg::TIME_W:0]   sum;
  logic [pbss_pkg::TIME_W-1:0] finish_time;
  logic                        append;

  localparam logic [pbss_pkg::IDX_W-1:0] LAST_IDX =
    pbss_pkg::IDX_W'(pbss_pkg::BUFFER_DEPTH - 1);
  localparam logic [pbss_pkg::LIM_W-1:0] DEPTH_LIM =
    pbss_pkg::LIM_W'(pbss_pkg::BUFFER_DEPTH);

  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign occ_zero = (occ_r == '0);

  assign status.head_expired = !occ_zero && (rd_data_r <= arrival_r);

  // effective limit: size clamped into 1..depth
  assign size_ext = pbss_pkg::LIM_W'(buffer_size);
  always_comb begin
    if (size_ext == '0)          limit = pbss_pkg::LIM_W'(1);
    else if (size_ext > DEPTH_LIM) limit = DEPTH_LIM;
    else                         limit = size_ext;
  end

  assign full      = !occ_zero && (pbss_pkg::LIM_W'(occ_r) >= limit);
  assign start_sel = occ_zero ? arrival_r : last_finish_r;
  assign sum       = {1'b0, start_sel} + {{(pbss_pkg::TIME_W + 1 - pbss_pkg::DUR_W){1'b0}},
                     duration_r};
  assign finish_time = sum[pbss_pkg::TIME_W] ? '1 : sum[pbss_pkg::TIME_W-1:0];
  assign append      = cmd.finish && !full;

  // read address follows the head one step ahead so the data is ready next cycle
  assign rd_addr = cmd.pop ? head_inc : head_r;

  always_comb begin
    head_nxt = cmd.pop ? head_inc : head_r;
    tail_nxt = append ? tail_inc : tail_r;
    occ_nxt  = occ_r;
    if (cmd.pop)     occ_nxt = occ_r - 1'b1;
    else if (append) occ_nxt = occ_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= ring_mem[rd_addr];
    if (append) ring_mem[tail_r] <= finish_time;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arrival_r  <= in_arrival_time;
      duration_r <= in_duration;
    end
    if (append) last_finish_r <= finish_time;
    if (cmd.finish) begin
      out_start_r   <= full ? '0 : start_sel;
      out_dropped_r <= full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_start_time = out_start_r;
  assign out_dropped    = out_dropped_r;

endmodule

### rtl/core/packet_buffer_start_scheduler_unit.sv
// Top level of the packet buffer start scheduler: configuration port,
// controller and datapath. Depends on pbss_pkg, pbss_ctrl, pbss_dpath.

// Packet buffer start scheduler. Give a packet word (arrival time, duration)
// with start high while busy is low; the block then removes every buffered
// packet whose finish time is at or before the arrival, and emits one result
// word on out_start_time/out_dropped marked by a single-cycle out_valid
// strobe. The receiver cannot stall: take each result in the cycle it is
// shown. A packet is captured, then retires its expired buffered entries,
// then is decided; the head entry is read from the finish-time ring one
// per cycle, and every entry is retired once. The result is shown in the
// first cycle that busy is low again, and the next word may be given in
// that same cycle. buffer_size (register 0, byte address 0) is clamped
// into 1..64 and may be written only while busy is low; lowering it below
// the current fill keeps held packets and drops new ones until enough
// expire.
module packet_buffer_start_scheduler_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // packet input
  input  logic                          start,
  output logic                          busy,
  input  logic [pbss_pkg::TIME_W-1:0]   in_arrival_time,
  input  logic [pbss_pkg::DUR_W-1:0]    in_duration,
  // result output
  output logic                          out_valid,
  output logic [pbss_pkg::TIME_W-1:0]   out_start_time,
  output logic                          out_dropped,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbss_pkg::PADDR_W-1:0]  paddr,
  input  logic [pbss_pkg::PDATA_W-1:0]  pwdata,
  output logic [pbss_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [pbss_pkg::SIZE_W-1:0] buffer_size_r;
  logic                        cfg_wr;
  logic                        cfg_sel_size;
  pbss_pkg::pbss_cmd_t         cmd;
  pbss_pkg::pbss_status_t      status;

  // Zero-wait-state port: every access completes in its access phase.
  assign pready       = 1'b1;
  assign cfg_sel_size = (paddr[pbss_pkg::PADDR_W-1:2] == pbss_pkg::REG_BUFFER_SIZE);
  assign cfg_wr       = psel && penable && pwrite && pready;

  // Hold the buffer size; writes to unmapped addresses drop silently.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= pbss_pkg::SIZE_RESET;
    end else if (cfg_wr && cfg_sel_size) begin
      buffer_size_r <= pwdata[pbss_pkg::SIZE_W-1:0];
    end
  end

  assign prdata = cfg_sel_size ? pbss_pkg::PDATA_W'(buffer_size_r) : '0;

  // Sequence each packet: capture, retire expired entries, decide.
  pbss_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Ring of finish times, pointers and result registers.
  pbss_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .buffer_size     (buffer_size_r),
    .in_arrival_time (in_arrival_time),
    .in_duration     (in_duration),
    .out_valid       (out_valid),
    .out_start_time  (out_start_time),
    .out_dropped     (out_dropped)
  );

endmodule
